/* src/lzfg_pkg.sv */
package lzfg_pkg;

	localparam int LENGTH_BITS  = 5;
	localparam int OFFSET_BITS  = 11;
	localparam int MAX_MATCH    = (1 << LENGTH_BITS) - 1;
	localparam int WINDOW       = (1 << OFFSET_BITS) - 1;
	localparam int RING_AW      = OFFSET_BITS + 1;
	localparam int RING_DEPTH   = 1 << RING_AW;
	localparam int MIN_MATCH    = 2;
	localparam int TOKEN_BITS   = 16;
	localparam int GROUP_TOKENS = 8;
	localparam int GROUP_BYTES  = 2 * GROUP_TOKENS;
	localparam int GB_AW        = $clog2(GROUP_BYTES);
	localparam int GB_CW        = $clog2(GROUP_BYTES + 1);
	localparam int GT_AW        = $clog2(GROUP_TOKENS);
	localparam int GT_CW        = $clog2(GROUP_TOKENS + 1);
	localparam logic [31:0] LIMIT_RESET = 32'hFFFF_FFFF;
	localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

	typedef logic [LENGTH_BITS-1:0] len_t;
	typedef logic [OFFSET_BITS-1:0] off_t;
	typedef logic [RING_AW-1:0]     pos_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        stored;
		logic        run_end;
		logic        stream_end;
		logic [31:0] total_length;
	} out_t;

	// one coding job: lookahead count at the first head and the stream end mark
	typedef struct packed {
		len_t cnt;
		logic fin;
	} cmd_t;

	typedef enum logic {
		MSG_TOKEN = 1'b0,
		MSG_FLUSH = 1'b1
	} msg_kind_t;

	typedef struct packed {
		msg_kind_t  kind;
		logic       literal;
		logic [7:0] hi;
		logic [7:0] lo;
		logic       tail;
		logic       fin;
	} tok_t;

endpackage

/* src/lzfg_ram.sv */
module lzfg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

/* src/lzfg_front.sv */
module lzfg_front import lzfg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  in_t        data,
	output logic       ram_we,
	output pos_t       ram_waddr,
	output logic [7:0] ram_wdata,
	output logic       cmd_push,
	output cmd_t       cmd,
	input  logic       cmd_full
);

	len_t count_q;
	pos_t wr_q;
	logic accept;
	len_t cnt_inc;
	logic look_full;

	assign accept    = push & ~cmd_full;
	assign full      = cmd_full;
	assign cnt_inc   = count_q + len_t'(1);
	assign look_full = (cnt_inc == len_t'(MAX_MATCH));

	assign ram_we    = accept;
	assign ram_waddr = wr_q;
	assign ram_wdata = data.data_byte;

	assign cmd_push  = accept & (data.final_byte | look_full);
	assign cmd.cnt   = cnt_inc;
	assign cmd.fin   = data.final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wr_q    <= '0;
		end else if (accept) begin
			wr_q <= wr_q + pos_t'(1);
			if (data.final_byte) begin
				count_q <= '0;
			end else if (look_full) begin
				count_q <= len_t'(MAX_MATCH - 1);
			end else begin
				count_q <= cnt_inc;
			end
		end
	end

endmodule

/* src/lzfg_cmdq.sv */
module lzfg_cmdq import lzfg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t rdata
);

	cmd_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] n_q;

	assign full  = (n_q == 2'd2);
	assign valid = (n_q != 2'd0);
	assign rdata = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			ent_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			n_q  <= 2'd0;
		end else begin
			if (push && !full) begin
				wp_q <= ~wp_q;
			end
			if (pop && valid) begin
				rp_q <= ~rp_q;
			end
			n_q <= n_q + 2'((push && !full) ? 1 : 0) - 2'((pop && valid) ? 1 : 0);
		end
	end

endmodule

/* src/lzfg_match.sv */
module lzfg_match import lzfg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       cmd_pop,
	output pos_t       raddr_a,
	output pos_t       raddr_b,
	input  logic [7:0] rdata_a,
	input  logic [7:0] rdata_b,
	output logic       tok_valid,
	output tok_t       tok,
	input  logic       tok_ready
);

	typedef enum logic [7:0] {
		M_IDLE  = 8'b0000_0001,
		M_HEAD  = 8'b0000_0010,
		M_LIT   = 8'b0000_0100,
		M_RD    = 8'b0000_1000,
		M_CMP   = 8'b0001_0000,
		M_TOK   = 8'b0010_0000,
		M_ADV   = 8'b0100_0000,
		M_FLUSH = 8'b1000_0000
	} mst_t;

	mst_t       st_q;
	pos_t       head_q;
	off_t       fill_q;
	len_t       skip_q;
	len_t       lac_q;
	logic       fin_q;
	off_t       d_q;
	len_t       len_q;
	len_t       best_len_q;
	off_t       best_off_q;
	logic [7:0] lit_q;

	logic                  eq;
	len_t                  len_inc;
	logic                  cand_done;
	len_t                  cand_len;
	logic                  better;
	len_t                  nbest;
	logic                  last_cand;
	logic                  literal;
	len_t                  remaining;
	logic [TOKEN_BITS-1:0] tokw;

	assign raddr_a = head_q + pos_t'(len_q) - pos_t'(d_q);
	assign raddr_b = (st_q == M_HEAD) ? head_q : head_q + pos_t'(len_q);

	assign eq        = (rdata_a == rdata_b);
	assign len_inc   = len_q + len_t'(1);
	assign cand_done = ~eq | (len_inc == lac_q);
	assign cand_len  = eq ? len_inc : len_q;
	assign better    = (cand_len > best_len_q);
	assign nbest     = better ? cand_len : best_len_q;
	assign last_cand = (d_q == off_t'(1)) | (nbest == lac_q);

	assign literal   = (best_len_q < len_t'(MIN_MATCH));
	assign remaining = lac_q - len_t'(1);
	assign tokw      = TOKEN_BITS'({best_off_q, best_len_q});

	assign cmd_pop   = (st_q == M_IDLE) & cmd_valid;
	assign tok_valid = (st_q == M_TOK) | (st_q == M_FLUSH);

	always_comb begin
		tok.kind    = (st_q == M_FLUSH) ? MSG_FLUSH : MSG_TOKEN;
		tok.literal = literal;
		tok.hi      = literal ? lit_q : tokw[15:8];
		tok.lo      = tokw[7:0];
		tok.fin     = fin_q;
		// no further token in this job: last head, or the rest is skipped
		if (st_q == M_FLUSH || !fin_q) begin
			tok.tail = 1'b1;
		end else if (literal) begin
			tok.tail = (remaining == len_t'(0));
		end else begin
			tok.tail = (remaining <= best_len_q - len_t'(1));
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			M_IDLE: begin
				if (cmd_valid) begin
					lac_q <= cmd.cnt;
					fin_q <= cmd.fin;
				end
			end
			M_LIT: begin
				lit_q      <= rdata_b;
				best_len_q <= '0;
				best_off_q <= '0;
				d_q        <= fill_q;
				len_q      <= '0;
			end
			M_CMP: begin
				if (!cand_done) begin
					len_q <= len_inc;
				end else begin
					if (better) begin
						best_len_q <= cand_len;
						best_off_q <= d_q;
					end
					d_q   <= d_q - off_t'(1);
					len_q <= '0;
				end
			end
			M_ADV: begin
				lac_q <= remaining;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= M_IDLE;
			head_q <= '0;
			fill_q <= '0;
			skip_q <= '0;
		end else begin
			case (st_q)
				M_IDLE: begin
					if (cmd_valid) begin
						st_q <= M_HEAD;
					end
				end
				M_HEAD: begin
					if (skip_q != len_t'(0)) begin
						skip_q <= skip_q - len_t'(1);
						st_q   <= M_ADV;
					end else begin
						st_q <= M_LIT;
					end
				end
				M_LIT: begin
					st_q <= (fill_q == off_t'(0)) ? M_TOK : M_RD;
				end
				M_RD: begin
					st_q <= M_CMP;
				end
				M_CMP: begin
					if (!cand_done || !last_cand) begin
						st_q <= M_RD;
					end else begin
						st_q <= M_TOK;
					end
				end
				M_TOK: begin
					if (tok_ready) begin
						skip_q <= literal ? len_t'(0) : best_len_q - len_t'(1);
						st_q   <= M_ADV;
					end
				end
				M_ADV: begin
					head_q <= head_q + pos_t'(1);
					if (fill_q != off_t'(WINDOW)) begin
						fill_q <= fill_q + off_t'(1);
					end
					if (!fin_q) begin
						st_q <= M_IDLE;
					end else if (lac_q == len_t'(1)) begin
						st_q <= M_FLUSH;
					end else begin
						st_q <= M_HEAD;
					end
				end
				M_FLUSH: begin
					if (tok_ready) begin
						fill_q <= '0;
						skip_q <= '0;
						st_q   <= M_IDLE;
					end
				end
				default: begin
					st_q <= M_IDLE;
				end
			endcase
		end
	end

endmodule

/* src/lzfg_pack.sv */
module lzfg_pack import lzfg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tok_valid,
	input  tok_t        tok,
	output logic        tok_ready,
	input  logic [31:0] limit,
	input  logic        pop,
	output logic        empty,
	output out_t        result
);

	typedef enum logic [2:0] {
		P_IDLE = 3'b001,
		P_FLAG = 3'b010,
		P_BODY = 3'b100
	} pst_t;

	pst_t                    st_q;
	logic [7:0]              gb_q [GROUP_BYTES];
	logic [GB_CW-1:0]        gbc_q;
	logic [GT_CW-1:0]        gtc_q;
	logic [GROUP_TOKENS-1:0] flags_q;
	logic [31:0]             be_q;
	logic                    run_q;
	logic                    strm_q;
	logic                    clr_q;
	logic [GT_AW-1:0]        t_q;
	logic [GB_AW-1:0]        pos_q;
	logic                    half_q;
	logic                    both_q;
	logic                    ov_q;
	out_t                    out_q;

	logic             slot;
	logic             emit;
	logic             take;
	logic [GT_CW-1:0] gtc_inc;
	logic             lit_t;
	logic             last;
	logic             both_now;
	logic [31:0]      be_inc;
	logic [7:0]       ob;
	logic             st_bit;

	assign slot      = ~ov_q | pop;
	assign emit      = slot & ((st_q == P_FLAG) | (st_q == P_BODY));
	assign tok_ready = (st_q == P_IDLE);
	assign take      = tok_valid & tok_ready;
	assign gtc_inc   = gtc_q + GT_CW'(1);
	assign lit_t     = flags_q[t_q];
	assign last      = (st_q == P_BODY) & (({1'b0, t_q} + GT_CW'(1)) == gtc_q)
		& (lit_t | half_q);
	// a match token is marked stored only when both of its bytes fit
	assign both_now  = ({1'b0, be_q} + 33'd1) < {1'b0, limit};
	assign be_inc    = (be_q == COUNT_MAX) ? be_q : be_q + 32'd1;

	always_comb begin
		if (st_q == P_FLAG) begin
			ob     = flags_q;
			st_bit = (be_q < limit);
		end else begin
			ob = gb_q[pos_q];
			if (lit_t) begin
				st_bit = (be_q < limit);
			end else if (half_q) begin
				st_bit = both_q;
			end else begin
				st_bit = both_now;
			end
		end
	end

	assign empty  = ~ov_q;
	assign result = out_q;

	always_ff @(posedge clk) begin
		if (take && tok.kind == MSG_TOKEN) begin
			gb_q[gbc_q[GB_AW-1:0]] <= tok.hi;
			if (!tok.literal) begin
				gb_q[gbc_q[GB_AW-1:0] + GB_AW'(1)] <= tok.lo;
			end
		end
		if (emit) begin
			out_q.out_byte     <= ob;
			out_q.stored       <= st_bit;
			out_q.run_end      <= last & run_q;
			out_q.stream_end   <= last & strm_q;
			out_q.total_length <= be_inc;
			if (st_q == P_BODY && !lit_t && !half_q) begin
				both_q <= both_now;
			end
		end
		if (take && tok.kind == MSG_TOKEN && gtc_inc == GT_CW'(GROUP_TOKENS)) begin
			run_q  <= tok.tail;
			strm_q <= tok.tail & tok.fin;
			clr_q  <= 1'b0;
		end else if (take && tok.kind == MSG_FLUSH) begin
			run_q  <= 1'b1;
			strm_q <= 1'b1;
			clr_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= P_IDLE;
			gbc_q   <= '0;
			gtc_q   <= '0;
			flags_q <= '0;
			be_q    <= '0;
			t_q     <= '0;
			pos_q   <= '0;
			half_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (emit) begin
				ov_q <= 1'b1;
			end else if (pop) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				P_IDLE: begin
					if (take && tok.kind == MSG_TOKEN) begin
						gtc_q <= gtc_inc;
						if (tok.literal) begin
							flags_q[gtc_q[GT_AW-1:0]] <= 1'b1;
							gbc_q <= gbc_q + GB_CW'(1);
						end else begin
							gbc_q <= gbc_q + GB_CW'(2);
						end
						if (gtc_inc == GT_CW'(GROUP_TOKENS)) begin
							st_q <= P_FLAG;
						end
					end else if (take) begin
						if (gtc_q != '0) begin
							st_q <= P_FLAG;
						end else begin
							be_q <= '0;
						end
					end
				end
				P_FLAG: begin
					if (emit) begin
						be_q   <= be_inc;
						t_q    <= '0;
						pos_q  <= '0;
						half_q <= 1'b0;
						st_q   <= P_BODY;
					end
				end
				P_BODY: begin
					if (emit) begin
						be_q  <= (last && clr_q) ? 32'd0 : be_inc;
						pos_q <= pos_q + GB_AW'(1);
						if (lit_t || half_q) begin
							t_q    <= t_q + GT_AW'(1);
							half_q <= 1'b0;
						end else begin
							half_q <= 1'b1;
						end
						if (last) begin
							gbc_q   <= '0;
							gtc_q   <= '0;
							flags_q <= '0;
							st_q    <= P_IDLE;
						end
					end
				end
				default: begin
					st_q <= P_IDLE;
				end
			endcase
		end
	end

endmodule

/* src/lz77_flag_group_compressor.sv */
// channel  | direction | handshake            | payload
// input    | in        | push / full          | data   (in_t)
// result   | out       | pop / empty          | result (out_t)
// limit    | in        | limit_we, no wait    | limit_wdata
//
// the front takes one byte a cycle into the ring and queues a coding job
// when the lookahead fills or the final byte arrives; a two-entry job
// queue stalls input once the coder falls behind
// coding a head compares bytes on the two ring ram ports at each candidate
// offset, oldest first, until offset 1 or a match that spans the lookahead
// output bytes leave through one result register; reset needs no clearing pass
module lz77_flag_group_compressor import lzfg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  in_t         data,
	output logic        empty,
	input  logic        pop,
	output out_t        result,
	input  logic        limit_we,
	input  logic [31:0] limit_wdata
);

	logic [31:0] limit_q;
	logic        ram_we;
	pos_t        ram_waddr;
	logic [7:0]  ram_wdata;
	pos_t        raddr_a;
	pos_t        raddr_b;
	logic [7:0]  rdata_a;
	logic [7:0]  rdata_b;
	logic        cmd_push;
	cmd_t        cmd_in;
	logic        cmd_full;
	logic        cmd_pop;
	logic        cmd_valid;
	cmd_t        cmd_out;
	logic        tok_valid;
	tok_t        tok;
	logic        tok_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (limit_we) begin
			limit_q <= limit_wdata;
		end
	end

	lzfg_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a),
		.raddr_b (raddr_b),
		.rdata_b (rdata_b)
	);

	lzfg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data      (data),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in),
		.cmd_full  (cmd_full)
	);

	lzfg_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.valid  (cmd_valid),
		.rdata  (cmd_out)
	);

	lzfg_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.raddr_a   (raddr_a),
		.raddr_b   (raddr_b),
		.rdata_a   (rdata_a),
		.rdata_b   (rdata_b),
		.tok_valid (tok_valid),
		.tok       (tok),
		.tok_ready (tok_ready)
	);

	lzfg_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok       (tok),
		.tok_ready (tok_ready),
		.limit     (limit_q),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

/* src/lzfg_checker.sv */
module lzfg_checker import lzfg_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input out_t        result,
	input logic        limit_we,
	input logic [31:0] limit_wdata
);

	logic [31:0] lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= LIMIT_RESET;
		end else if (limit_we) begin
			lim_q <= limit_wdata;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.stream_end |-> result.run_end)
		else $error("stream end without run end");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.total_length != 32'd0)
		else $error("result with zero byte count");

	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.stored |-> result.total_length <= lim_q)
		else $error("stored byte beyond output limit");

	// the job queue only fills on an accepted item
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		!full && !push |=> !full)
		else $error("full rose without an accepted item");

endmodule

bind lz77_flag_group_compressor lzfg_checker u_lzfg_checker (.*);
